@@ rtl/core/dfhe_pkg.sv @@
// Shared types and constants for the DEFLATE fixed-Huffman encoder.
// Used by the front end, the chunk queue, the bit packer and the top level.
package dfhe_pkg;

  // Request kinds on the input channel
  localparam logic [1:0] REQ_LITERAL = 2'd0;
  localparam logic [1:0] REQ_MATCH   = 2'd1;
  localparam logic [1:0] REQ_FLUSH   = 2'd2;

  // Longest bit string one item can produce: 8-bit length code, 5 extra,
  // 5-bit distance code, 13 extra.
  localparam int CHUNK_BITS  = 31;
  localparam int CHUNK_CNT_W = 5;

  // Decoupling queue between front end and packer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item: bits in transmit order, first bit in bit 0.
  typedef struct packed {
    logic                   flush;
    logic [CHUNK_CNT_W-1:0] cnt;
    logic [CHUNK_BITS-1:0]  bits;
  } chunk_t;

endpackage

@@ rtl/core/dfhe_front.sv @@
// Front end: classifies an input item and builds its bit string.
// Depends on dfhe_pkg for chunk_t and the request codes.
module dfhe_front (
  input  logic                 in_valid,
  input  logic                 q_full,
  input  logic [1:0]           req_type,
  input  logic [8:0]           literal_symbol,
  input  logic [8:0]           match_length,
  input  logic [15:0]          match_distance,
  output logic                 in_stall,
  output logic                 push,
  output dfhe_pkg::chunk_t     chunk
);
  import dfhe_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [3:0] len;
    logic [8:0] rev;
  } sym_code_t;

  // Fixed literal/length code, bit-reversed so the code MSB goes out first
  function automatic sym_code_t fixed_code(input logic [8:0] s);
    sym_code_t  r;
    logic [8:0] c;
    logic [8:0] rv;
    r.ok = 1'b1;
    c    = '0;
    if (s < 9'd144) begin
      c     = 9'h030 + s;
      r.len = 4'd8;
    end else if (s < 9'd256) begin
      c     = 9'h190 + (s - 9'd144);
      r.len = 4'd9;
    end else if (s < 9'd280) begin
      c     = s - 9'd256;
      r.len = 4'd7;
    end else if (s < 9'd288) begin
      c     = 9'h0C0 + (s - 9'd280);
      r.len = 4'd8;
    end else begin
      r.ok  = 1'b0;
      r.len = 4'd0;
    end
    for (int i = 0; i < 9; i++) begin
      rv[i] = c[8-i];
    end
    r.rev = rv >> (4'd9 - r.len);
    return r;
  endfunction

  function automatic logic [3:0] top_bit(input logic [14:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  logic [7:0]             l;
  logic [2:0]             l_nb;
  logic [2:0]             le;
  logic [8:0]             lsym;
  logic [7:0]             lx;
  logic [14:0]            d;
  logic [3:0]             d_nb;
  logic [3:0]             de;
  logic [4:0]             dcode;
  logic [4:0]             drev;
  logic [14:0]            dx;
  sym_code_t              lc;
  sym_code_t              sc;
  logic [CHUNK_CNT_W-1:0] pos1;
  logic [CHUNK_CNT_W-1:0] pos2;
  logic [CHUNK_CNT_W-1:0] pos3;
  logic                   keep;

  // Length: saturate, then split into code symbol and extra bits
  always_comb begin
    if (match_length < 9'd3) begin
      l = 8'd0;
    end else if (match_length > 9'd258) begin
      l = 8'd255;
    end else begin
      l = 8'(match_length - 9'd3);
    end
    l_nb = 3'(top_bit({7'd0, l}));
    le   = '0;
    lx   = '0;
    if (l < 8'd8) begin
      lsym = 9'd257 + {1'b0, l};
    end else if (l == 8'd255) begin
      lsym = 9'd285;
    end else begin
      le   = l_nb - 3'd2;
      lsym = 9'd257 + {4'd0, l_nb - 3'd1, 2'b00} + {7'd0, 2'(l >> le)};
      lx   = l & ((8'd1 << le) - 8'd1);
    end
    lc = fixed_code(lsym);
  end

  // Distance: saturate, then split into 5-bit code and extra bits
  always_comb begin
    if (match_distance == 16'd0) begin
      d = '0;
    end else if (match_distance[15]) begin
      d = 15'h7FFF;
    end else begin
      d = match_distance[14:0] - 15'd1;
    end
    d_nb = top_bit(d);
    de   = '0;
    dx   = '0;
    if (d < 15'd4) begin
      dcode = 5'(d);
    end else begin
      de    = d_nb - 4'd1;
      dcode = {d_nb, 1'b0} + {4'd0, d[de]};
      dx    = d & ((15'd1 << de) - 15'd1);
    end
    for (int i = 0; i < 5; i++) begin
      drev[i] = dcode[4-i];
    end
  end

  assign pos1 = CHUNK_CNT_W'(lc.len);
  assign pos2 = pos1 + CHUNK_CNT_W'(le);
  assign pos3 = pos2 + CHUNK_CNT_W'(5);

  always_comb begin
    chunk = '0;
    keep  = 1'b0;
    sc    = fixed_code(literal_symbol);
    case (req_type)
      REQ_LITERAL: begin
        keep       = sc.ok;
        chunk.bits = CHUNK_BITS'(sc.rev);
        chunk.cnt  = CHUNK_CNT_W'(sc.len);
      end
      REQ_MATCH: begin
        keep       = 1'b1;
        chunk.bits = CHUNK_BITS'(lc.rev)
                   | (CHUNK_BITS'(lx) << pos1)
                   | (CHUNK_BITS'(drev) << pos2)
                   | (CHUNK_BITS'(dx) << pos3);
        chunk.cnt  = pos3 + CHUNK_CNT_W'(de);
      end
      REQ_FLUSH: begin
        keep        = 1'b1;
        chunk.flush = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Drop items that produce nothing; stall only on a full queue
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

@@ rtl/core/dfhe_queue.sv @@
// Small FIFO of classified chunks between the front end and the packer.
// Depends on dfhe_pkg for chunk_t and the queue depth.
module dfhe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dfhe_pkg::chunk_t push_chunk,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output dfhe_pkg::chunk_t head
);
  import dfhe_pkg::*;

  chunk_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/dfhe_back.sv @@
// Bit packer: merges chunks into the pending byte and emits up to one byte a
// cycle while out_stall allows. Depends on dfhe_pkg for chunk_t.
module dfhe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  dfhe_pkg::chunk_t head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);
  import dfhe_pkg::*;

  localparam int ACC_W    = CHUNK_BITS - 1;
  localparam int MERGE_W  = CHUNK_BITS + 7;
  localparam int TOTAL_W  = CHUNK_CNT_W + 1;

  // acc holds bits not yet sent, acc_cnt how many; bits above acc_cnt are zero
  logic [ACC_W-1:0]       acc;
  logic [CHUNK_CNT_W-1:0] acc_cnt;
  logic [ACC_W-1:0]       acc_next;
  logic [CHUNK_CNT_W-1:0] acc_cnt_next;
  logic [MERGE_W-1:0]     merged;
  logic [TOTAL_W-1:0]     total;
  logic                   has_work;
  logic                   need_emit;
  logic                   act;
  logic                   out_free;
  logic [7:0]             byte_val;
  logic                   byte_last;

  assign out_free = !out_valid || !out_stall;
  assign merged   = {{(MERGE_W-7){1'b0}}, acc[6:0]}
                  | (MERGE_W'(head.bits) << acc_cnt[2:0]);
  assign total    = TOTAL_W'(acc_cnt) + TOTAL_W'(head.cnt);

  always_comb begin
    has_work     = 1'b0;
    need_emit    = 1'b0;
    pop          = 1'b0;
    byte_val     = acc[7:0];
    byte_last    = 1'b0;
    acc_next     = acc;
    acc_cnt_next = acc_cnt;
    if (acc_cnt >= CHUNK_CNT_W'(8)) begin
      // drain a full byte left over from the current item
      has_work     = 1'b1;
      need_emit    = 1'b1;
      byte_last    = (acc_cnt < CHUNK_CNT_W'(16));
      acc_next     = {8'd0, acc[ACC_W-1:8]};
      acc_cnt_next = acc_cnt - CHUNK_CNT_W'(8);
    end else if (head_valid && !head.flush) begin
      // merge the next chunk and, with a full byte, send it in the same cycle
      has_work  = 1'b1;
      need_emit = (total >= TOTAL_W'(8));
      byte_val  = merged[7:0];
      byte_last = (total < TOTAL_W'(16));
      if (need_emit) begin
        acc_next     = merged[MERGE_W-1:8];
        acc_cnt_next = CHUNK_CNT_W'(total - TOTAL_W'(8));
      end else begin
        acc_next     = merged[ACC_W-1:0];
        acc_cnt_next = CHUNK_CNT_W'(total);
      end
    end else if (head_valid) begin
      // flush: pad the partial byte with zeros
      has_work     = 1'b1;
      need_emit    = (acc_cnt != '0);
      byte_last    = 1'b1;
      acc_next     = '0;
      acc_cnt_next = '0;
    end
    act = has_work && (!need_emit || out_free);
    pop = act && (acc_cnt < CHUNK_CNT_W'(8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (act) begin
        acc     <= acc_next;
        acc_cnt <= acc_cnt_next;
      end
      if (out_free) begin
        out_valid <= act && need_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act && need_emit) begin
      out_byte    <= byte_val;
      last_of_run <= byte_last;
    end
  end

endmodule

@@ rtl/core/deflate_fixed_huffman_encoder_top.sv @@
// DEFLATE fixed-Huffman (BTYPE=01) symbol encoder. Each transfer on the input
// channel is a literal/length symbol, a length-distance match, or a flush; the
// output channel carries the resulting bitstream as bytes, first bit in bit 0,
// with last_of_run marking the final byte an item caused. Huffman codes go out
// MSB first and extra-bit fields LSB first. Symbols above 287 and request
// type 3 are dropped without output; lengths and distances outside their
// ranges saturate. A flush with no pending bits yields nothing. The front end
// takes one item per cycle while its four-entry chunk queue has room; the
// packer sends up to one byte per cycle while out_stall allows. Each item's
// chunk is first registered in the chunk queue, and its first byte then in
// the output register.
module deflate_fixed_huffman_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [8:0]  literal_symbol,
  input  logic [8:0]  match_length,
  input  logic [15:0] match_distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);
  import dfhe_pkg::*;

  logic   push;
  logic   pop;
  logic   q_full;
  logic   head_valid;
  chunk_t push_chunk;
  chunk_t head;

  // Classify the item and build its bit string; drop items with no output
  dfhe_front u_front (
    .in_valid       (in_valid),
    .q_full         (q_full),
    .req_type       (req_type),
    .literal_symbol (literal_symbol),
    .match_length   (match_length),
    .match_distance (match_distance),
    .in_stall       (in_stall),
    .push           (push),
    .chunk          (push_chunk)
  );

  // Hold classified chunks so input and output can stall independently
  dfhe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_chunk (push_chunk),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Pack bits into bytes and transfer them through the output register
  dfhe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
